[rtl/core/fk_pkg.sv]
// Shared constants, register codes and the arctangent table function for the
// two-link forward kinematics block. No dependencies.
`timescale 1ns / 1ps

package fk_pkg;

    localparam int FK_CORDIC_STEPS = 24;

    // Angle constants, Q.24 and Q16.16 degrees
    localparam logic [51:0] FK_FULL24   = 52'd6039797760;
    localparam logic [51:0] FK_RED_OFS  = FK_FULL24 << 18;
    localparam int          FK_RED_STEPS = 19;
    localparam logic signed [35:0] FK_HALF24  = 36'sd3019898880;
    localparam logic signed [35:0] FK_RIGHT24 = 36'sd1509949440;
    localparam logic [25:0] FK_FULL16   = 26'd23592960;
    localparam logic signed [35:0] FK_GAIN_Q30 = 36'sd652032874;
    localparam logic signed [29:0] FK_XY_LIMIT = 30'sd33554430;

    typedef enum logic [2:0] {
        REG_ORIENT     = 3'd0,
        REG_LIMIT_ONE  = 3'd1,
        REG_LIMIT_TWO  = 3'd2,
        REG_STEP_ONE   = 3'd3,
        REG_STEP_TWO   = 3'd4,
        REG_LENGTH_ONE = 3'd5,
        REG_LENGTH_TWO = 3'd6
    } fk_reg_t;

    typedef enum logic [1:0] {
        CMD_STEPS     = 2'd0,
        CMD_HOMED_ONE = 2'd1,
        CMD_HOMED_TWO = 2'd2,
        CMD_NONE      = 2'd3
    } fk_cmd_t;

    // atan(2^-i) in degrees, 24 fraction bits, from the odd power series
    function automatic logic [63:0] fk_atan(input int i);
        logic [63:0] base;
        logic [63:0] acc;
        logic [63:0] term;
        int          sh;
        base = 64'd961263669 << 32;
        acc  = 64'd0;
        if (i == 0)
        begin
            return 64'd45 << 24;
        end
        for (int k = 0; k < 32; k++)
        begin
            sh = i * (2 * k + 1);
            if (sh < 64)
            begin
                term = (base >> sh) / 64'(2 * k + 1);
                if (k % 2 == 1)
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
        end
        return (acc + 64'h8000_0000) >> 32;
    endfunction

endpackage

[rtl/core/fk_if.sv]
// Valid/ready channel interfaces for the request and result items.
// Depends on nothing.
`timescale 1ns / 1ps

interface fk_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [23:0] first_steps;
    logic signed [23:0] second_steps;

    modport source (output valid, cmd, first_steps, second_steps, input ready);
    modport sink   (input valid, cmd, first_steps, second_steps, output ready);
endinterface

interface fk_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [25:0] x_pos;
    logic signed [25:0] y_pos;
    logic [24:0]        joint_one_angle;
    logic [24:0]        joint_two_angle;

    modport source (output valid, x_pos, y_pos, joint_one_angle, joint_two_angle,
                    input ready);
    modport sink   (input valid, x_pos, y_pos, joint_one_angle, joint_two_angle,
                    output ready);
endinterface

[rtl/core/fk_angle_red.sv]
// Joint angle unit: home angle plus steps times step angle, reduced modulo
// 360 degrees by a shared compare-subtract stage. Depends on fk_pkg.
`timescale 1ns / 1ps

module fk_angle_red
    import fk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               ccw,
    input  logic signed [25:0] limit,
    input  logic [25:0]        per_step,
    input  logic signed [23:0] steps,
    input  logic               use_steps,
    output logic               done,
    output logic [24:0]        angle
);

    logic               busy_reg;
    logic               load_reg;
    logic               done_reg;
    logic [4:0]         cnt_reg;
    logic signed [50:0] prod_reg;
    logic signed [35:0] home_reg;
    logic [51:0]        val_reg;

    logic signed [35:0] lim24;
    logic signed [35:0] home_next;
    logic signed [53:0] sum_next;
    logic [51:0]        cand;

    assign lim24     = 36'(limit) <<< 8;
    assign home_next = ccw ? (-FK_RIGHT24 - lim24) : (FK_RIGHT24 + lim24);
    assign sum_next  = 54'(prod_reg) + 54'(home_reg) + $signed({2'b00, FK_RED_OFS});
    assign cand      = FK_FULL24 << cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            load_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                load_reg <= 1'b1;
            end
            else if (load_reg)
            begin
                load_reg <= 1'b0;
                cnt_reg  <= 5'(FK_RED_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= use_steps ? 51'(steps) * 51'($signed({1'b0, per_step})) : '0;
            home_reg <= home_next;
        end
        else if (load_reg)
        begin
            val_reg <= sum_next[51:0];
        end
        else if (busy_reg && val_reg >= cand)
        begin
            val_reg <= val_reg - cand;
        end
    end

    assign done  = done_reg;
    assign angle = val_reg[32:8];

endmodule

[rtl/core/fk_cordic.sv]
// Iterative rotation-mode CORDIC giving sine and cosine, 30 fraction bits,
// of an angle in Q16.16 degrees. Depends on fk_pkg.
`timescale 1ns / 1ps

module fk_cordic
    import fk_pkg::*;
#(
    parameter int CORDIC_STEPS = FK_CORDIC_STEPS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [24:0]        angle,
    output logic               done,
    output logic signed [35:0] sin_q,
    output logic signed [35:0] cos_q
);

    localparam int CW = $clog2(CORDIC_STEPS);

    logic signed [35:0] atan_tab [CORDIC_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_atan
        assign atan_tab[g] = 36'(fk_atan(g));
    end

    logic               busy_reg;
    logic               done_reg;
    logic               neg_reg;
    logic [CW-1:0]      cnt_reg;
    logic signed [35:0] x_reg;
    logic signed [35:0] y_reg;
    logic signed [35:0] z_reg;

    logic signed [35:0] z_in;
    logic signed [35:0] z_wrap;
    logic signed [35:0] z_fold;
    logic               neg_fold;
    logic signed [35:0] dx;
    logic signed [35:0] dy;

    always_comb
    begin
        z_in   = $signed({3'b000, angle, 8'h00});
        z_wrap = (z_in > FK_HALF24) ? z_in - $signed({1'b0, FK_FULL24[34:0]}) : z_in;
        if (z_wrap > FK_RIGHT24)
        begin
            z_fold   = z_wrap - FK_HALF24;
            neg_fold = 1'b1;
        end
        else if (z_wrap < -FK_RIGHT24)
        begin
            z_fold   = z_wrap + FK_HALF24;
            neg_fold = 1'b1;
        end
        else
        begin
            z_fold   = z_wrap;
            neg_fold = 1'b0;
        end
    end

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= FK_GAIN_Q30;
            y_reg   <= '0;
            z_reg   <= z_fold;
            neg_reg <= neg_fold;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_tab[cnt_reg];
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_tab[cnt_reg];
            end
        end
    end

    assign done  = done_reg;
    assign sin_q = neg_reg ? -y_reg : y_reg;
    assign cos_q = neg_reg ? -x_reg : x_reg;

endmodule

[rtl/core/two_link_forward_kinematics_unit.sv]
// Two-link arm forward kinematics, top level: configuration registers,
// sequencer and the coordinate multiply-accumulate. Depends on fk_pkg, fk_if,
// fk_angle_red and fk_cordic.
//
//  channel | dir | payload                                             | handshake
//  req     | in  | cmd, first_steps, second_steps                      | valid/ready
//  rsp     | out | x_pos, y_pos, joint_one_angle, joint_two_angle      | valid/ready
//  cfg     | in  | cfg_index, cfg_data                                 | cfg_we only
//
// One item at a time. A step command takes two angle reductions (one
// multiply, one add, 19 compare-subtract passes each), then two CORDIC runs,
// the multiply-accumulate and the output step; homed commands skip one
// reduction, the unused command skips both.
// Reset clears the joint angles and the configuration registers to zero.
// A result waits in the output register; the next item is taken meanwhile and
// its result holds in the sequencer until the output register is free.
`timescale 1ns / 1ps

module two_link_forward_kinematics_unit
    import fk_pkg::*;
#(
    parameter int CORDIC_STEPS = FK_CORDIC_STEPS
)
(
    input  logic        clk,
    input  logic        rst_n,
    fk_req_if.sink      req,
    fk_rsp_if.source    rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [25:0] cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RED1 = 8'b0000_0010,
        S_RED2 = 8'b0000_0100,
        S_SUM  = 8'b0000_1000,
        S_COR1 = 8'b0001_0000,
        S_COR2 = 8'b0010_0000,
        S_MAC  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    // configuration
    logic [1:0]         orient_reg;
    logic signed [25:0] limit_one_reg;
    logic signed [25:0] limit_two_reg;
    logic [25:0]        step_one_reg;
    logic [25:0]        step_two_reg;
    logic [23:0]        length_one_reg;
    logic [23:0]        length_two_reg;

    // sequencer
    state_t             state_reg;
    state_t             state_next;
    logic [1:0]         cmd_reg;
    logic signed [23:0] steps_two_reg;
    logic [24:0]        angle_one_reg;
    logic [24:0]        angle_two_reg;
    logic [24:0]        sum_reg;
    logic signed [35:0] s1_reg;
    logic signed [35:0] c1_reg;
    logic signed [35:0] s12_reg;
    logic signed [35:0] c12_reg;
    logic [2:0]         mac_cnt_reg;
    logic signed [58:0] prod_reg;
    logic signed [60:0] acc_x_reg;
    logic signed [60:0] acc_y_reg;

    // output register
    logic               out_valid_reg;
    logic signed [25:0] x_reg;
    logic signed [25:0] y_reg;
    logic [24:0]        j1_reg;
    logic [24:0]        j2_reg;

    logic               accept;
    logic               out_free;

    logic               red_start;
    logic               red_joint;
    logic signed [23:0] red_steps;
    logic               red_use;
    logic               red_done;
    logic [24:0]        red_angle;

    logic               cor_start;
    logic [24:0]        cor_angle;
    logic               cor_done;
    logic signed [35:0] cor_sin;
    logic signed [35:0] cor_cos;

    logic [25:0]        sum_raw;
    logic [23:0]        mac_len;
    logic signed [35:0] mac_t;
    logic signed [25:0] x_sat;
    logic signed [25:0] y_sat;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg     <= '0;
            limit_one_reg  <= '0;
            limit_two_reg  <= '0;
            step_one_reg   <= '0;
            step_two_reg   <= '0;
            length_one_reg <= '0;
            length_two_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIENT:     orient_reg     <= cfg_data[1:0];
                REG_LIMIT_ONE:  limit_one_reg  <= cfg_data;
                REG_LIMIT_TWO:  limit_two_reg  <= cfg_data;
                REG_STEP_ONE:   step_one_reg   <= cfg_data;
                REG_STEP_TWO:   step_two_reg   <= cfg_data;
                REG_LENGTH_ONE: length_one_reg <= cfg_data[23:0];
                REG_LENGTH_TWO: length_two_reg <= cfg_data[23:0];
                default:        ;
            endcase
        end
    end

    // Sequencer: pick the next phase and launch the shared units
    always_comb
    begin
        state_next = state_reg;
        red_start  = 1'b0;
        red_joint  = 1'b0;
        red_steps  = req.first_steps;
        red_use    = 1'b0;
        cor_start  = 1'b0;
        cor_angle  = angle_one_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        CMD_STEPS:
                        begin
                            red_start  = 1'b1;
                            red_use    = 1'b1;
                            state_next = S_RED1;
                        end
                        CMD_HOMED_ONE:
                        begin
                            red_start  = 1'b1;
                            state_next = S_RED1;
                        end
                        CMD_HOMED_TWO:
                        begin
                            red_start  = 1'b1;
                            red_joint  = 1'b1;
                            state_next = S_RED2;
                        end
                        default: state_next = S_SUM;
                    endcase
                end
            end
            S_RED1:
            begin
                if (red_done)
                begin
                    if (cmd_reg == CMD_STEPS)
                    begin
                        red_start  = 1'b1;
                        red_joint  = 1'b1;
                        red_steps  = steps_two_reg;
                        red_use    = 1'b1;
                        state_next = S_RED2;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_RED2:
            begin
                if (red_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cor_start  = 1'b1;
                state_next = S_COR1;
            end
            S_COR1:
            begin
                if (cor_done)
                begin
                    cor_start  = 1'b1;
                    cor_angle  = sum_reg;
                    state_next = S_COR2;
                end
            end
            S_COR2:
            begin
                if (cor_done)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (mac_cnt_reg == 3'd4)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    fk_angle_red u_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (red_start),
        .ccw       (red_joint ? orient_reg[1] : orient_reg[0]),
        .limit     (red_joint ? limit_two_reg : limit_one_reg),
        .per_step  (red_joint ? step_two_reg : step_one_reg),
        .steps     (red_steps),
        .use_steps (red_use),
        .done      (red_done),
        .angle     (red_angle)
    );

    fk_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .angle (cor_angle),
        .done  (cor_done),
        .sin_q (cor_sin),
        .cos_q (cor_cos)
    );

    // Joint sum folded once into a full turn
    assign sum_raw = {1'b0, angle_one_reg} + {1'b0, angle_two_reg};

    // Products in order: L1*s1, L2*s12, L1*c1, L2*c12
    always_comb
    begin
        case (mac_cnt_reg)
            3'd0:    begin mac_len = length_one_reg; mac_t = s1_reg;  end
            3'd1:    begin mac_len = length_two_reg; mac_t = s12_reg; end
            3'd2:    begin mac_len = length_one_reg; mac_t = c1_reg;  end
            default: begin mac_len = length_two_reg; mac_t = c12_reg; end
        endcase
    end

    function automatic logic signed [25:0] clamp_xy(input logic signed [60:0] acc);
        logic signed [30:0] r;
        r = 31'(acc >>> 30);
        if (r > 31'(FK_XY_LIMIT))
        begin
            return 26'(FK_XY_LIMIT);
        end
        else if (r < -31'(FK_XY_LIMIT))
        begin
            return -26'(FK_XY_LIMIT);
        end
        return r[25:0];
    endfunction

    assign x_sat = clamp_xy(acc_x_reg);
    assign y_sat = clamp_xy(acc_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            angle_one_reg <= '0;
            angle_two_reg <= '0;
            mac_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_RED1 && red_done)
            begin
                angle_one_reg <= red_angle;
            end
            if (state_reg == S_RED2 && red_done)
            begin
                angle_two_reg <= red_angle;
            end
            if (state_reg == S_MAC)
            begin
                mac_cnt_reg <= mac_cnt_reg + 3'd1;
            end
            else
            begin
                mac_cnt_reg <= '0;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: held operands, CORDIC results, accumulators, result item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= req.cmd;
            steps_two_reg <= req.second_steps;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= (sum_raw >= FK_FULL16) ? 25'(sum_raw - FK_FULL16) : sum_raw[24:0];
        end
        if (state_reg == S_COR1 && cor_done)
        begin
            s1_reg <= cor_sin;
            c1_reg <= cor_cos;
        end
        if (state_reg == S_COR2 && cor_done)
        begin
            s12_reg   <= cor_sin;
            c12_reg   <= cor_cos;
            acc_x_reg <= 61'sd1 <<< 29;
            acc_y_reg <= 61'sd1 <<< 29;
        end
        if (state_reg == S_MAC)
        begin
            prod_reg <= 59'($signed({1'b0, mac_len})) * 59'(mac_t);
            if (mac_cnt_reg == 3'd1 || mac_cnt_reg == 3'd2)
            begin
                acc_x_reg <= acc_x_reg + 61'(prod_reg);
            end
            if (mac_cnt_reg == 3'd3 || mac_cnt_reg == 3'd4)
            begin
                acc_y_reg <= acc_y_reg + 61'(prod_reg);
            end
        end
        if (state_reg == S_OUT && out_free)
        begin
            x_reg  <= x_sat;
            y_reg  <= y_sat;
            j1_reg <= angle_one_reg;
            j2_reg <= angle_two_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.x_pos           = x_reg;
    assign rsp.y_pos           = y_reg;
    assign rsp.joint_one_angle = j1_reg;
    assign rsp.joint_two_angle = j2_reg;

    a_red_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        red_done |-> (state_reg == S_RED1 || state_reg == S_RED2))
        else $error("angle unit finished outside a reduction phase");

    a_cor_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> (state_reg == S_COR1 || state_reg == S_COR2))
        else $error("CORDIC finished outside a rotation phase");

    a_angles_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, angle_one_reg} < FK_FULL16) && ({1'b0, angle_two_reg} < FK_FULL16))
        else $error("joint angle beyond a full turn");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("sequencer stayed idle after taking an item");

endmodule

[dv/fk_tb_pkg.sv]
// Testbench-side types for the two-link kinematics bench.
// Depends on fk_pkg.
`timescale 1ns / 1ps

package fk_tb_pkg;
    import fk_pkg::*;

    typedef struct packed {
        logic signed [25:0] x_pos;
        logic signed [25:0] y_pos;
        logic [24:0]        joint_one_angle;
        logic [24:0]        joint_two_angle;
    } fk_pose_t;

    typedef struct packed {
        fk_cmd_t            cmd;
        logic signed [23:0] first_steps;
        logic signed [23:0] second_steps;
    } fk_move_t;
endpackage

[dv/tb_top.sv]
// Self-checking bench for the two-link forward kinematics unit: directed
// table then random moves, each result checked against an in-bench pose model.
// Depends on fk_pkg, fk_if, fk_tb_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_top;
    import fk_pkg::*;
    import fk_tb_pkg::*;

    localparam longint FULL16 = 64'd23592960;
    localparam longint FULL24 = 64'd6039797760;
    localparam longint HALF24 = 64'd3019898880;
    localparam longint RIGHT24 = 64'd1509949440;
    localparam longint RIGHT16 = 64'd5898240;
    localparam longint XY_SAT = 64'd33554430;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [25:0] cfg_data = '0;

    fk_req_if req ();
    fk_rsp_if rsp ();

    two_link_forward_kinematics_unit uut
    (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Shadow copies of the registers and the joint state
    logic [1:0]  sh_orient;
    longint      sh_limit [2];
    longint      sh_step [2];
    longint      sh_len [2];
    longint      pose_one, pose_two;
    longint      arctan_q24 [32];

    fk_pose_t    pending_poses [$];
    int          failures = 0;
    longint      cycle_count = 0;
    bit          stall_rx = 1'b0;
    bit          hold_rx = 1'b0;
    bit          quiet_rx = 1'b0;
    bit          quiet_tx = 1'b0;

    // Floor shift for signed values
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint mod_pos(longint v, longint m);
        longint r;
        r = v % m;
        if (r < 0)
        begin
            r += m;
        end
        return r;
    endfunction

    // Sine and cosine (Q30) of a Q16.16 angle in [0,360)
    task automatic rotate_unit(input longint deg16, output longint sn, output longint cs);
        longint z, x, y, dx, dy;
        bit     flip;
        z = deg16 * 256;
        x = 64'd652032874;
        y = 0;
        flip = 1'b0;
        if (z > HALF24)
        begin
            z -= FULL24;
        end
        if (z > RIGHT24)
        begin
            z -= HALF24;
            flip = 1'b1;
        end
        else if (z < -RIGHT24)
        begin
            z += HALF24;
            flip = 1'b1;
        end
        for (int i = 0; i < FK_CORDIC_STEPS; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_q24[i];
            end
            else
            begin
                x += dx; y -= dy; z += arctan_q24[i];
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    function automatic longint blend_links(longint t1, longint t2);
        longint r;
        r = shr_floor(sh_len[0] * t1 + sh_len[1] * t2 + (64'sd1 <<< 29), 30);
        if (r > XY_SAT)
        begin
            r = XY_SAT;
        end
        if (r < -XY_SAT)
        begin
            r = -XY_SAT;
        end
        return r;
    endfunction

    function automatic longint home_angle(int j);
        longint h;
        h = sh_orient[j] ? (-RIGHT16 - sh_limit[j]) : (RIGHT16 + sh_limit[j]);
        return mod_pos(h, FULL16);
    endfunction

    function automatic longint joint_from_steps(int j, longint steps);
        longint h;
        h = sh_orient[j] ? (-RIGHT24 - sh_limit[j] * 256) : (RIGHT24 + sh_limit[j] * 256);
        return mod_pos(h + steps * sh_step[j], FULL24) / 256;
    endfunction

    // Advance the joint state and work out the pose reported for one move
    task automatic predict_pose(input fk_move_t mv, output fk_pose_t pz);
        longint s1, c1, s12, c12;
        case (mv.cmd)
            CMD_STEPS:
            begin
                pose_one = joint_from_steps(0, longint'(mv.first_steps));
                pose_two = joint_from_steps(1, longint'(mv.second_steps));
            end
            CMD_HOMED_ONE: pose_one = home_angle(0);
            CMD_HOMED_TWO: pose_two = home_angle(1);
            default: ;
        endcase
        rotate_unit(pose_one, s1, c1);
        rotate_unit(mod_pos(pose_one + pose_two, FULL16), s12, c12);
        pz.x_pos = 26'(blend_links(s1, s12));
        pz.y_pos = 26'(blend_links(c1, c12));
        pz.joint_one_angle = 25'(pose_one);
        pz.joint_two_angle = 25'(pose_two);
    endtask

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input fk_reg_t idx, input logic [25:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_ORIENT:     sh_orient = val[1:0];
            REG_LIMIT_ONE:  sh_limit[0] = longint'($signed(val));
            REG_LIMIT_TWO:  sh_limit[1] = longint'($signed(val));
            REG_STEP_ONE:   sh_step[0] = longint'(val);
            REG_STEP_TWO:   sh_step[1] = longint'(val);
            REG_LENGTH_ONE: sh_len[0] = longint'(val[23:0]);
            default:        sh_len[1] = longint'(val[23:0]);
        endcase
    endtask

    task automatic load_setting(input logic [1:0] o, input logic [25:0] l1, l2, a1, a2,
                                input logic [23:0] m1, m2);
        write_reg(REG_ORIENT, 26'(o));
        write_reg(REG_LIMIT_ONE, l1);
        write_reg(REG_LIMIT_TWO, l2);
        write_reg(REG_STEP_ONE, a1);
        write_reg(REG_STEP_TWO, a2);
        write_reg(REG_LENGTH_ONE, 26'(m1));
        write_reg(REG_LENGTH_TWO, 26'(m2));
        cfg_we <= 1'b0;
    endtask

    // Offer one move and hold it until the unit takes it; record its expected pose
    task automatic offer_move(input fk_move_t mv, input bit typed, input fk_pose_t typed_pose);
        fk_pose_t pz;
        while (!quiet_tx && $urandom_range(0, 99) < 33)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= mv.cmd;
        req.first_steps <= mv.first_steps;
        req.second_steps <= mv.second_steps;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        predict_pose(mv, pz);
        if (typed && pz != typed_pose)
        begin
            $error("table row disagrees with pose model: %h vs %h", typed_pose, pz);
            failures++;
        end
        pending_poses.push_back(pz);
    endtask

    function automatic fk_move_t random_move();
        fk_move_t mv;
        int sel;
        sel = $urandom_range(0, 99);
        mv.cmd = sel < 80 ? CMD_STEPS : sel < 88 ? CMD_HOMED_ONE :
                 sel < 96 ? CMD_HOMED_TWO : CMD_NONE;
        mv.first_steps = $urandom_range(0, 3) == 0 ? 24'($urandom) :
                         24'($signed(12'($urandom)));
        mv.second_steps = $urandom_range(0, 3) == 0 ? 24'($urandom) :
                          24'($signed(12'($urandom)));
        return mv;
    endfunction

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_poses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (150) @(posedge clk);
    endtask

    // Result side: random stalls, one long hold-off, compare in order
    always @(posedge clk)
    begin
        fk_pose_t want;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (rsp.valid && rsp.ready)
            begin
                if (pending_poses.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    failures++;
                end
                else
                begin
                    want = pending_poses.pop_front();
                    if (rsp.x_pos !== want.x_pos)
                    begin
                        $error("x_pos expected %0d got %0d", want.x_pos, rsp.x_pos);
                        failures++;
                    end
                    if (rsp.y_pos !== want.y_pos)
                    begin
                        $error("y_pos expected %0d got %0d", want.y_pos, rsp.y_pos);
                        failures++;
                    end
                    if (rsp.joint_one_angle !== want.joint_one_angle)
                    begin
                        $error("joint_one_angle expected %0d got %0d",
                               want.joint_one_angle, rsp.joint_one_angle);
                        failures++;
                    end
                    if (rsp.joint_two_angle !== want.joint_two_angle)
                    begin
                        $error("joint_two_angle expected %0d got %0d",
                               want.joint_two_angle, rsp.joint_two_angle);
                        failures++;
                    end
                end
            end
            rsp.ready <= !hold_rx && (quiet_rx || $urandom_range(0, 99) >= 33);
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Long hold-off of the receiver, counted here while the sender keeps offering
    initial
    begin
        wait (stall_rx);
        hold_rx = 1'b1;
        repeat (2000) @(posedge clk);
        hold_rx = 1'b0;
    end

    typedef struct {
        fk_move_t mv;
        bit       typed;
        fk_pose_t pz;
    } table_row_t;

    table_row_t plan [$];

    initial
    begin
        fk_pose_t zero_pose;
        fk_move_t mv;
        int idx;
        zero_pose = '0;
        req.valid = 1'b0;
        req.cmd = CMD_STEPS;
        req.first_steps = '0;
        req.second_steps = '0;
        rsp.ready = 1'b0;
        sh_orient = '0;
        sh_limit = '{0, 0};
        sh_step = '{0, 0};
        sh_len = '{0, 0};
        pose_one = 0;
        pose_two = 0;
        for (int i = 0; i < 32; i++)
        begin
            arctan_q24[i] = longint'(fk_atan(i));
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero registers after reset: zero lengths put the end point at the
        // origin, and every joint sits at its clockwise home of 90 degrees
        plan.push_back('{'{CMD_STEPS, 24'sh7FFFFF, -24'sh800000}, 1'b1,
                         '{26'sd0, 26'sd0, 25'd5898240, 25'd5898240}});
        plan.push_back('{'{CMD_NONE, 24'sh0, 24'sh0}, 1'b1,
                         '{26'sd0, 26'sd0, 25'd5898240, 25'd5898240}});
        plan.push_back('{'{CMD_HOMED_ONE, 24'sh0, 24'sh0}, 1'b1,
                         '{26'sd0, 26'sd0, 25'd5898240, 25'd5898240}});
        foreach (plan[i])
        begin
            offer_move(plan[i].mv, plan[i].typed, plan[i].pz);
        end
        drain();

        // Extremes: largest lengths drive the coordinates into saturation
        load_setting(2'd0, 26'sd23592959, -26'sd23592959, 26'h3FFFFFF, 26'h3FFFFFF,
                     24'hFFFFFF, 24'hFFFFFF);
        plan = {};
        plan.push_back('{'{CMD_HOMED_ONE, 24'sh0, 24'sh0}, 1'b0, zero_pose});
        plan.push_back('{'{CMD_HOMED_TWO, 24'sh0, 24'sh0}, 1'b0, zero_pose});
        plan.push_back('{'{CMD_STEPS, 24'sh7FFFFF, 24'sh7FFFFF}, 1'b0, zero_pose});
        plan.push_back('{'{CMD_STEPS, -24'sh800000, -24'sh800000}, 1'b0, zero_pose});
        plan.push_back('{'{CMD_STEPS, 24'sh555555, -24'sh2AAAAB}, 1'b0, zero_pose});
        plan.push_back('{'{CMD_NONE, 24'sh0, 24'sh0}, 1'b0, zero_pose});
        foreach (plan[i])
        begin
            offer_move(plan[i].mv, plan[i].typed, plan[i].pz);
        end
        drain();

        // Counter-clockwise homing, one degree per step on the first joint and half a degree on the second, modest arms
        load_setting(2'd3, -26'sd23592959, 26'sd23592959, 26'd16777216, 26'd8388608,
                     24'd25600, 24'd12800);
        plan = {};
        for (int s = -4; s <= 4; s++)
        begin
            plan.push_back('{'{CMD_STEPS, 24'(s * 45), 24'(s * 90)}, 1'b0, zero_pose});
        end
        plan.push_back('{'{CMD_HOMED_ONE, 24'sh0, 24'sh0}, 1'b0, zero_pose});
        plan.push_back('{'{CMD_HOMED_TWO, 24'sh0, 24'sh0}, 1'b0, zero_pose});
        foreach (plan[i])
        begin
            offer_move(plan[i].mv, plan[i].typed, plan[i].pz);
        end
        drain();

        // Random phases, each with a fresh random setting
        for (int ph = 0; ph < 6; ph++)
        begin
            load_setting(2'($urandom), 26'($signed($urandom_range(0, 47185918)) - 23592959),
                         26'($signed($urandom_range(0, 47185918)) - 23592959),
                         ph == 0 ? 26'd0 : 26'($urandom), 26'($urandom >> $urandom_range(0, 20)),
                         ph == 1 ? 24'd0 : 24'($urandom), 24'($urandom >> $urandom_range(0, 12)));
            quiet_rx = (ph == 2);
            quiet_tx = (ph == 2);
            if (ph == 3)
            begin
                stall_rx = 1'b1;
            end
            for (idx = 0; idx < 305; idx++)
            begin
                mv = random_move();
                offer_move(mv, 1'b0, zero_pose);
            end
            drain();
        end

        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
